// ----- rtl/core/lru_replacement_tracker_top_defines.svh -----
// Assertion macros for the LRU replacement tracker.
`ifndef LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define LRT_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LRT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lru_trk_pkg.sv -----
// Package: opcodes, word types and defaults for the LRU replacement tracker.
`timescale 1ns / 1ps

package lru_trk_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int OPCODE_W        = 3;
   localparam int SLOT_W          = 4;
   localparam int OCC_W           = 5;

   localparam logic [OPCODE_W-1:0] OP_ACCESS = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_EVICT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SLOT_W-1:0]   slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] victim_slot;
      logic              victim_found;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

// ----- rtl/core/lru_replacement_tracker_top.sv -----
// LRU replacement tracker: input register, rank update logic, result register.
// Each word passes from the input register to the result register behind rsp_valid.
// Throughput: one word per cycle unless stalled; all ranks update combinationally.
// rsp_stall holds the result register and, once the input register is also full,
// backs up into req_stall.
// Reset (synchronous, active high) empties the tracker and both pipeline registers.
`timescale 1ns / 1ps

module lru_replacement_tracker_top #(
   parameter int ENTRIES = lru_trk_pkg::DEFAULT_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lru_trk_pkg::req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lru_trk_pkg::rsp_type rsp_word
);

   localparam int RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CntW  = $clog2(ENTRIES + 1);

   lru_trk_pkg::req_type req_ff;
   logic                 req_vld_ff;
   lru_trk_pkg::rsp_type rsp_ff, rsp_in;
   logic                 rsp_vld_ff;

   logic [ENTRIES-1:0]   tracked_ff, tracked_in;
   logic [RankW-1:0]     rank_ff [ENTRIES];
   logic [RankW-1:0]     rank_in [ENTRIES];
   logic [CntW-1:0]      count_ff, count_in;

   logic out_free;
   logic go;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign go        = req_vld_ff && out_free;
   assign req_stall = req_vld_ff && !out_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      logic [ENTRIES-1:0] match;
      logic [ENTRIES-1:0] vmatch;
      logic [ENTRIES-1:0] dmatch;
      logic [RankW-1:0]   r;
      logic [RankW-1:0]   oldest;
      logic [RankW-1:0]   dr;
      logic [RankW-1:0]   vic;
      logic               hit;
      logic               found;
      logic               do_promote;
      logic               do_insert;
      logic               do_drop;
      logic               do_clear;

      oldest = RankW'(count_ff - CntW'(1));
      r      = '0;
      vic    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = (32'(req_ff.slot) == i);
         vmatch[i] = tracked_ff[i] && (rank_ff[i] == oldest);
         r         = r | ({RankW{match[i]}} & rank_ff[i]);
         // ranks are unique, so at most one slot matches
         vic       = vic | ({RankW{vmatch[i]}} & RankW'(i));
      end
      hit   = |(match & tracked_ff);
      found = (count_ff != '0) && (|vmatch);

      do_promote = 1'b0;
      do_insert  = 1'b0;
      do_drop    = 1'b0;
      do_clear   = 1'b0;
      unique case (req_ff.opcode)
         lru_trk_pkg::OP_ACCESS: do_promote = hit;
         lru_trk_pkg::OP_ADD: begin
            do_promote = hit;
            do_insert  = !hit && (|match);
         end
         lru_trk_pkg::OP_REMOVE: do_drop  = hit;
         lru_trk_pkg::OP_EVICT:  do_drop  = found;
         lru_trk_pkg::OP_CLEAR:  do_clear = 1'b1;
         default: ;
      endcase

      dmatch = (req_ff.opcode == lru_trk_pkg::OP_EVICT) ? vmatch : match;
      dr     = (req_ff.opcode == lru_trk_pkg::OP_EVICT) ? oldest : r;

      tracked_in = tracked_ff;
      count_in   = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_clear) begin
            tracked_in[i] = 1'b0;
            rank_in[i]    = '0;
         end else if (do_promote) begin
            if (match[i]) begin
               rank_in[i] = '0;
            end else if (tracked_ff[i] && (rank_ff[i] < r)) begin
               rank_in[i] = rank_ff[i] + RankW'(1);
            end
         end else if (do_insert) begin
            if (match[i]) begin
               tracked_in[i] = 1'b1;
               rank_in[i]    = '0;
            end else if (tracked_ff[i]) begin
               rank_in[i] = rank_ff[i] + RankW'(1);
            end
         end else if (do_drop) begin
            if (dmatch[i]) begin
               tracked_in[i] = 1'b0;
               rank_in[i]    = '0;
            end else if (tracked_ff[i] && (rank_ff[i] > dr)) begin
               rank_in[i] = rank_ff[i] - RankW'(1);
            end
         end
      end

      if (do_clear) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + CntW'(1);
      end else if (do_drop) begin
         count_in = count_ff - CntW'(1);
      end

      rsp_in.victim_found = (req_ff.opcode == lru_trk_pkg::OP_EVICT) && found;
      rsp_in.victim_slot  = rsp_in.victim_found ? lru_trk_pkg::SLOT_W'(vic) : '0;
      rsp_in.occupancy    = lru_trk_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         tracked_ff <= '0;
         count_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            req_vld_ff <= req_valid;
         end
         if (out_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (go) begin
            tracked_ff <= tracked_in;
            count_ff   <= count_in;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_word;
      end
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/lru_trk_checker.sv -----
// Port-level checker for the LRU replacement tracker, bound to the top level.
`timescale 1ns / 1ps
`include "lru_replacement_tracker_top_defines.svh"

module lru_trk_checker #(
   parameter int ENTRIES = lru_trk_pkg::DEFAULT_ENTRIES
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input lru_trk_pkg::req_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lru_trk_pkg::rsp_type rsp_word
);

   logic req_seen;

   assign req_seen = req_valid && !req_stall && (req_word.opcode != lru_trk_pkg::OP_CLEAR);

   `LRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")
   `LRT_ASSERT_ALWAYS(a_occ_range, !rsp_valid || (32'(rsp_word.occupancy) <= ENTRIES), "occupancy above entry count")
   `LRT_ASSERT_ALWAYS(a_victim_zero, !rsp_valid || rsp_word.victim_found || (rsp_word.victim_slot == '0), "victim slot set without a victim")
   `LRT_ASSERT_ALWAYS(a_evict_room, !rsp_valid || !rsp_word.victim_found || (32'(rsp_word.occupancy) < ENTRIES) || !req_seen, "evict left a full tracker")

endmodule

bind lru_replacement_tracker_top lru_trk_checker #(.ENTRIES(ENTRIES)) u_lru_trk_checker (.*);

// ----- dv/lru_replacement_tracker_top_tb.sv -----
// Self-checking testbench for the LRU replacement tracker with a built-in recency predictor.
`timescale 1ns / 1ps

module lru_replacement_tracker_top_tb;

   localparam int SLOTS       = lru_trk_pkg::DEFAULT_ENTRIES;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;
   localparam logic [lru_trk_pkg::OPCODE_W-1:0] OP_SPARE_LO = lru_trk_pkg::OP_CLEAR + 3'd1;
   localparam logic [lru_trk_pkg::OPCODE_W-1:0] OP_SPARE_HI = '1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lru_trk_pkg::req_type req_word  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lru_trk_pkg::rsp_type rsp_word;

   // predictor state
   logic                           in_use[SLOTS];
   logic [lru_trk_pkg::SLOT_W-1:0] age_rank[SLOTS];
   logic [lru_trk_pkg::OCC_W-1:0]  live_count;

   lru_trk_pkg::req_type pending_ops[$];
   lru_trk_pkg::rsp_type predicted_outcomes[$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int cycle_count     = 0;
   int error_count     = 0;
   int words_accepted  = 0;
   int results_checked = 0;
   int victims_seen    = 0;
   int empty_evicts    = 0;
   int full_seen       = 0;

   lru_replacement_tracker_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void make_newest(int s);
      logic [lru_trk_pkg::SLOT_W-1:0] r;
      r = age_rank[s];
      for (int i = 0; i < SLOTS; i++) begin
         if (in_use[i] && age_rank[i] < r) age_rank[i]++;
      end
      age_rank[s] = '0;
   endfunction

   function automatic void forget_slot(int s);
      logic [lru_trk_pkg::SLOT_W-1:0] r;
      r = age_rank[s];
      for (int i = 0; i < SLOTS; i++) begin
         if (in_use[i] && age_rank[i] > r) age_rank[i]--;
      end
      in_use[s]   = 1'b0;
      age_rank[s] = '0;
      if (live_count > 0) live_count--;
   endfunction

   function automatic void wipe_order();
      for (int i = 0; i < SLOTS; i++) begin
         in_use[i]   = 1'b0;
         age_rank[i] = '0;
      end
      live_count = '0;
   endfunction

   function automatic lru_trk_pkg::rsp_type lru_apply(lru_trk_pkg::req_type w);
      lru_trk_pkg::rsp_type r;
      int                   s;
      r = '0;
      s = w.slot;
      case (w.opcode)
         lru_trk_pkg::OP_ACCESS: begin
            if (in_use[s]) make_newest(s);
         end
         lru_trk_pkg::OP_ADD: begin
            if (in_use[s]) begin
               make_newest(s);
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (in_use[i]) age_rank[i]++;
               end
               in_use[s]   = 1'b1;
               age_rank[s] = '0;
               live_count++;
            end
         end
         lru_trk_pkg::OP_REMOVE: begin
            if (in_use[s]) forget_slot(s);
         end
         lru_trk_pkg::OP_EVICT: begin
            if (live_count > 0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!r.victim_found && in_use[i] && age_rank[i] == live_count - 1) begin
                     r.victim_slot  = lru_trk_pkg::SLOT_W'(i);
                     r.victim_found = 1'b1;
                  end
               end
               if (r.victim_found) forget_slot(r.victim_slot);
            end
         end
         lru_trk_pkg::OP_CLEAR: begin
            wipe_order();
         end
         default: begin
         end
      endcase
      r.occupancy = live_count;
      return r;
   endfunction

   function automatic void queue_op(logic [lru_trk_pkg::OPCODE_W-1:0] op, int s);
      lru_trk_pkg::req_type w;
      w.opcode = op;
      w.slot   = lru_trk_pkg::SLOT_W'(s);
      pending_ops.insert(pending_ops.size(), w);
   endfunction

   // Mostly adds and accesses so the order fills up; occasional full fill bursts.
   task automatic queue_random_ops(int n);
      int order[SLOTS];
      int left;
      int pick;
      int tmp;
      int j;
      left = n;
      while (left > 0) begin
         if ($urandom_range(99) < 8 && left >= SLOTS) begin
            for (int i = 0; i < SLOTS; i++) order[i] = i;
            for (int i = SLOTS - 1; i > 0; i--) begin
               j        = $urandom_range(i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < SLOTS; i++) queue_op(lru_trk_pkg::OP_ADD, order[i]);
            left -= SLOTS;
         end else begin
            pick = $urandom_range(99);
            if (pick < 36)
               queue_op(lru_trk_pkg::OP_ADD, $urandom_range(SLOTS - 1));
            else if (pick < 62)
               queue_op(lru_trk_pkg::OP_ACCESS, $urandom_range(SLOTS - 1));
            else if (pick < 75)
               queue_op(lru_trk_pkg::OP_REMOVE, $urandom_range(SLOTS - 1));
            else if (pick < 94)
               queue_op(lru_trk_pkg::OP_EVICT, $urandom_range(SLOTS - 1));
            else if (pick < 97)
               queue_op(lru_trk_pkg::OP_CLEAR, $urandom_range(SLOTS - 1));
            else
               queue_op(lru_trk_pkg::OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                        $urandom_range(SLOTS - 1));
            left--;
         end
      end
   endtask

   task automatic wait_until_quiet();
      while (pending_ops.size() != 0 || req_valid || predicted_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_word.opcode == lru_trk_pkg::OP_EVICT && live_count == 0) empty_evicts++;
            predicted_outcomes.insert(predicted_outcomes.size(), lru_apply(req_word));
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= pending_ops[0];
               pending_ops.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_check
      lru_trk_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, expected none actual %p",
                        $time, rsp_word);
            end else begin
               want = predicted_outcomes[0];
               predicted_outcomes.delete(0);
               results_checked++;
               if (want.victim_found) victims_seen++;
               if (want.occupancy == SLOTS) full_seen++;
               if (rsp_word.victim_slot !== want.victim_slot) begin
                  error_count++;
                  $display("%0t: victim_slot mismatch, expected %0d actual %0d",
                           $time, want.victim_slot, rsp_word.victim_slot);
               end
               if (rsp_word.victim_found !== want.victim_found) begin
                  error_count++;
                  $display("%0t: victim_found mismatch, expected %0d actual %0d",
                           $time, want.victim_found, rsp_word.victim_found);
               end
               if (rsp_word.occupancy !== want.occupancy) begin
                  error_count++;
                  $display("%0t: occupancy mismatch, expected %0d actual %0d",
                           $time, want.occupancy, rsp_word.occupancy);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lru_replacement_tracker_top_tb: errors");
         $finish;
      end
   end

   initial begin
      wipe_order();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: corner cases on an empty and a partly filled order
      queue_op(lru_trk_pkg::OP_EVICT, 0);
      queue_op(lru_trk_pkg::OP_ACCESS, 5);
      queue_op(lru_trk_pkg::OP_REMOVE, 9);
      queue_op(lru_trk_pkg::OP_ADD, 0);
      queue_op(lru_trk_pkg::OP_ADD, 15);
      queue_op(lru_trk_pkg::OP_ADD, 7);
      queue_op(lru_trk_pkg::OP_ADD, 10);
      queue_op(lru_trk_pkg::OP_ADD, 0);      // already tracked: behaves as access
      queue_op(lru_trk_pkg::OP_ACCESS, 15);
      queue_op(lru_trk_pkg::OP_ACCESS, 3);
      queue_op(lru_trk_pkg::OP_REMOVE, 7);
      queue_op(lru_trk_pkg::OP_REMOVE, 7);
      queue_op(lru_trk_pkg::OP_EVICT, 0);
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
         queue_op(lru_trk_pkg::OPCODE_W'(op), 15);
      queue_op(lru_trk_pkg::OP_CLEAR, 15);
      queue_op(lru_trk_pkg::OP_EVICT, 15);
      queue_op(lru_trk_pkg::OP_ADD, 5);
      queue_op(lru_trk_pkg::OP_EVICT, 0);
      queue_op(lru_trk_pkg::OP_EVICT, 0);
      wait_until_quiet();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         queue_random_ops(160);
         wait_until_quiet();
      end

      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("%0d words accepted, %0d results checked over four pacing phases",
               words_accepted, results_checked);
      $display("%0d evictions returned a slot, %0d hit an empty order, %0d results at full",
               victims_seen, empty_evicts, full_seen);
      if (error_count == 0 && predicted_outcomes.size() == 0) begin
         $display("lru_replacement_tracker_top_tb: clean");
      end else begin
         $display("lru_replacement_tracker_top_tb: errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lru_trk_pkg.sv
rtl/core/lru_replacement_tracker_top.sv
rtl/core/lru_trk_checker.sv
dv/lru_replacement_tracker_top_tb.sv
